// ===== hw/rtl/lz78e_pkg.sv =====
`default_nettype none
package lz78e_pkg;

  localparam int DICT_DEPTH_DEF = 4096;
  localparam int CHAR_LIMIT_DEF = 128;
  localparam int DATA_W         = 8;
  // generation tag kept with every hash slot; zero marks a cleared slot
  localparam int EPOCH_W        = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lz78e_if.sv =====
`default_nettype none
interface lz78e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface lz78e_out_if #(
  parameter int IW = 12,
  parameter int CW = 7
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] token_char;
  logic [IW-1:0] prefix_index;
  logic          index_only;
  logic          final_token;
  modport source (output valid, token_char, prefix_index, index_only, final_token,
                  input ready);
  modport sink   (input valid, token_char, prefix_index, index_only, final_token,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lz78_dictionary_encoder.sv =====
`default_nettype none
// LZ78 dictionary encoder.
// in_ch  : one byte per transfer (data_byte, end_of_stream). Bytes at or
//          above CHAR_LIMIT are dropped; end_of_stream still flushes.
// out_ch : tokens (token_char, prefix_index, index_only, final_token),
//          zero or one per input byte, held in an output register.
// cfg_we/cfg_wdata write dict_limit (highest phrase index to assign);
//          write it only while the encoder is idle.
// Phrases live in a hashed table (DICT_DEPTH slots, one RAM, linear
// probing). A byte takes an accept step, a probe (address, then
// registered read + compare) per slot visited on the single RAM port,
// and an emit step. A matched byte skips emit unless it ends the stream;
// a dropped byte has only the accept step, plus the emit step at end of stream.
// Each slot carries a generation tag; end of stream bumps the tag, which
// empties the table at once. After reset, and whenever the tag wraps,
// a clearing sweep over all DICT_DEPTH slots runs with in_ch.ready low.
// A stalled out_ch holds the finished token; the encoder keeps working
// until it needs to load the next token, then waits in the emit step.
// DICT_DEPTH must be a power of two.
module lz78_dictionary_encoder #(
  parameter int DICT_DEPTH = lz78e_pkg::DICT_DEPTH_DEF,
  parameter int CHAR_LIMIT = lz78e_pkg::CHAR_LIMIT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [$clog2(DICT_DEPTH)-1:0] cfg_wdata,
  lz78e_in_if.sink                           in_ch,
  lz78e_out_if.source                        out_ch
);
  import lz78e_pkg::*;

  localparam int IW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(CHAR_LIMIT);
  localparam int WW = EPOCH_W + IW + CW + IW;   // {tag, parent, char, child}

  state_t state, state_next;

  logic [WW-1:0]      mem [DICT_DEPTH];
  logic [WW-1:0]      rd_q;
  logic [IW-1:0]      addr;
  logic [EPOCH_W-1:0] epoch;
  logic [IW-1:0]      dict_limit;
  logic [IW-1:0]      match;
  logic [IW:0]        nfi;           // next free phrase index
  logic [CW-1:0]      cur_char;
  logic               cur_eos;

  // pending token and end-of-stream work for the emit step
  logic          r_emit, r_end, r_idx_only, r_final;
  logic [CW-1:0] r_char;
  logic [IW-1:0] r_prefix;

  logic          o_valid;
  logic [CW-1:0] o_char;
  logic [IW-1:0] o_prefix;
  logic          o_idx_only, o_final;

  logic               in_ready, mem_we, out_free, emit_go, out_load;
  logic               byte_ok;
  logic [IW-1:0]      hash;
  logic [EPOCH_W-1:0] epoch_inc;
  logic               slot_used, slot_hit;
  logic [IW-1:0]      rd_child;

  assign byte_ok   = {1'b0, in_ch.data_byte} < (DATA_W+1)'(CHAR_LIMIT);
  assign hash      = match ^ (IW'(in_ch.data_byte[CW-1:0]) << (IW - CW));
  assign slot_used = rd_q[WW-1 -: EPOCH_W] == epoch;
  assign slot_hit  = slot_used && rd_q[IW+CW +: IW] == match
                     && rd_q[IW +: CW] == cur_char;
  assign rd_child  = rd_q[IW-1:0];
  assign epoch_inc = epoch + EPOCH_W'(1);
  assign out_free  = !o_valid || out_ch.ready;
  assign emit_go   = !r_emit || out_free;
  assign out_load  = state == ST_EMIT && emit_go && r_emit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (addr == IW'(DICT_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (byte_ok)            state_next = ST_PROBE;
          else if (in_ch.end_of_stream) state_next = ST_EMIT;
        end
      end
      ST_PROBE: state_next = ST_CMP;
      ST_CMP: begin
        if (slot_hit)       state_next = cur_eos ? ST_EMIT : ST_IDLE;
        else if (slot_used) state_next = ST_PROBE;
        else                state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_next = (r_end && epoch_inc == '0) ? ST_CLEAR : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    unique case (state)
      ST_CLEAR: mem_we   = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_CMP:   mem_we   = !slot_used && nfi <= {1'b0, dict_limit}
                           && nfi < (IW+1)'(DICT_DEPTH);
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // table RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= (state == ST_CLEAR) ? '0 : {epoch, match, cur_char, nfi[IW-1:0]};
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      addr       <= '0;
      epoch      <= EPOCH_W'(1);
      dict_limit <= IW'(DICT_DEPTH - 1);
      match      <= '0;
      nfi        <= (IW+1)'(1);
      o_valid    <= 1'b0;
      r_emit     <= 1'b0;
      r_end      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) dict_limit <= cfg_wdata;
      if (o_valid && out_ch.ready && !out_load) o_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          addr <= addr + IW'(1);
          if (addr == IW'(DICT_DEPTH - 1)) epoch <= EPOCH_W'(1);
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            cur_char <= in_ch.data_byte[CW-1:0];
            cur_eos  <= in_ch.end_of_stream;
            addr     <= hash;
            // dropped byte at end of stream: flush any pending match
            r_emit     <= match != '0;
            r_end      <= 1'b1;
            r_char     <= '0;
            r_prefix   <= match;
            r_idx_only <= 1'b1;
            r_final    <= 1'b1;
          end
        end
        ST_CMP: begin
          if (slot_hit) begin
            match      <= rd_child;
            r_emit     <= 1'b1;
            r_end      <= 1'b1;
            r_char     <= '0;
            r_prefix   <= rd_child;
            r_idx_only <= 1'b1;
            r_final    <= 1'b1;
          end else if (slot_used) begin
            addr <= addr + IW'(1);
          end else begin
            if (mem_we) nfi <= nfi + (IW+1)'(1);
            match      <= '0;
            r_emit     <= 1'b1;
            r_end      <= cur_eos;
            r_char     <= cur_char;
            r_prefix   <= match;
            r_idx_only <= 1'b0;
            r_final    <= cur_eos;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (r_emit) begin
              o_valid    <= 1'b1;
              o_char     <= r_char;
              o_prefix   <= r_prefix;
              o_idx_only <= r_idx_only;
              o_final    <= r_final;
            end
            if (r_end) begin
              match <= '0;
              nfi   <= (IW+1)'(1);
              epoch <= epoch_inc;
              addr  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.token_char   = o_char;
  assign out_ch.prefix_index = o_prefix;
  assign out_ch.index_only   = o_idx_only;
  assign out_ch.final_token  = o_final;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |-> epoch != '0)
    else $error("zero generation tag in use");
  a_nfi_range: assert property (@(posedge clk) disable iff (rst)
    nfi != '0 && nfi <= (IW+1)'(DICT_DEPTH))
    else $error("free index out of range");
  a_match_assigned: assert property (@(posedge clk) disable iff (rst)
    {1'b0, match} < nfi)
    else $error("match names an unassigned phrase");

endmodule
`default_nettype wire
